/* design/assert_macros.svh */
// assertion macros shared by the link sorter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the trigger
`define ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* design/slrs_pkg.sv */
// package: link record type, sizes, register indexes and the ordering compare
`timescale 1ns / 1ps

package slrs_pkg;

	// store depth and derived widths
	localparam int MAX_LINKS = 16;
	localparam int IDX_W     = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
	localparam int CNT_W     = $clog2(MAX_LINKS + 1);

	// field widths
	localparam int TAG_W  = 16;
	localparam int RANK_W = 16;
	localparam int RATE_W = 20;

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = RATE_W;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BITRATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BITRATE = 1'b1;
	localparam logic [RATE_W-1:0]    MAX_RATE_RESET  = '1;

	// input commands
	localparam logic CMD_ADD      = 1'b0;
	localparam logic CMD_FINALIZE = 1'b1;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [RANK_W-1:0] rank;
		logic [RATE_W-1:0] bitrate;
	} link_rec_t;

	// true if record a goes out before record b
	function automatic logic link_before(link_rec_t a, logic a_play,
			link_rec_t b, logic b_play);
		logic r;
		if (a_play != b_play) begin
			r = a_play;
		end else if (a_play) begin
			r = (a.rank != b.rank) ? (a.rank > b.rank) : (a.bitrate > b.bitrate);
		end else begin
			r = (a.bitrate != b.bitrate) ? (a.bitrate < b.bitrate) : (a.rank > b.rank);
		end
		return r;
	endfunction

endpackage

/* design/stream_link_ranking_sorter_top.sv */
// link ranking sorter: collects link records and, on finalize, streams them
// out playable first (rank then bit rate, both descending), then stuttering
// (bit rate ascending, rank descending), equal keys in arrival order. A
// finalize over n stored links runs one selection pass per result: each pass
// scans the store through its single read port into one shared compare unit
// and can be held by an output stall; input is stalled until the last result
// is loaded into the output register.
`timescale 1ns / 1ps

module stream_link_ranking_sorter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [slrs_pkg::TAG_W-1:0]       link_tag,
	input  logic [slrs_pkg::RANK_W-1:0]      link_rank,
	input  logic [slrs_pkg::RATE_W-1:0]      link_bitrate,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [slrs_pkg::TAG_W-1:0]       out_tag,
	output logic [slrs_pkg::RANK_W-1:0]      out_rank,
	output logic [slrs_pkg::RATE_W-1:0]      out_bitrate,
	output logic                             is_stuttering,
	output logic                             dropped_any,
	output logic                             last_item,
	// configuration
	input  logic                             cfg_we,
	input  logic [slrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slrs_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import slrs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [RATE_W-1:0]     min_rate_q;
	logic [RATE_W-1:0]     max_rate_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      done_q;
	logic                  ovf_q;
	logic [MAX_LINKS-1:0]  emitted_q;
	logic [IDX_W-1:0]      rd_idx_q;

	link_rec_t             store_mem [MAX_LINKS];
	link_rec_t             rd_rec_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic                  rd_vld_s1;

	link_rec_t             best_q;
	logic                  best_play_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic                  best_vld_q;

	logic                  out_valid_q;
	link_rec_t             out_rec_q;
	logic                  out_stut_q;
	logic                  out_drop_q;
	logic                  out_last_q;

	logic                  in_beat;
	logic                  add_ok;
	logic                  last_rd;
	logic                  cand_play;
	logic                  cand_take;
	logic                  out_load;
	logic                  last_pick;
	link_rec_t             in_rec;

	// handshake and decode
	assign in_stall  = (state_q != ST_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign add_ok    = in_beat && (command == CMD_ADD) && (count_q < CNT_W'(MAX_LINKS));
	assign in_rec    = '{tag: link_tag, rank: link_rank, bitrate: link_bitrate};
	assign last_rd   = (CNT_W'(rd_idx_q) == count_q - CNT_W'(1));
	assign last_pick = (done_q + CNT_W'(1) == count_q);
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// shared compare unit: window test and ordering against the best so far
	assign cand_play = (rd_rec_s1.bitrate >= min_rate_q) && (rd_rec_s1.bitrate <= max_rate_q);
	assign cand_take = rd_vld_s1 && !emitted_q[rd_idx_s1] &&
		(!best_vld_q || link_before(rd_rec_s1, cand_play, best_q, best_play_q));

	// link store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (add_ok) begin
			store_mem[count_q[IDX_W-1:0]] <= in_rec;
		end
		rd_rec_s1 <= store_mem[rd_idx_q];
		rd_idx_s1 <= rd_idx_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q <= '0;
			max_rate_q <= MAX_RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_BITRATE: min_rate_q <= cfg_data;
				REG_MAX_BITRATE: max_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: add, scan passes and emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			done_q     <= '0;
			ovf_q      <= 1'b0;
			emitted_q  <= '0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat && command == CMD_ADD) begin
						if (add_ok) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end else if (in_beat) begin
						if (count_q == '0) begin
							ovf_q <= 1'b0;
						end else begin
							state_q    <= ST_SCAN;
							rd_idx_q   <= '0;
							done_q     <= '0;
							emitted_q  <= '0;
							best_vld_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (last_rd) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						emitted_q[best_idx_q] <= 1'b1;
						done_q     <= done_q + CNT_W'(1);
						best_vld_q <= 1'b0;
						rd_idx_q   <= '0;
						if (last_pick) begin
							state_q <= ST_IDLE;
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cand_take) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	// best candidate payload
	always_ff @(posedge clk) begin
		if (cand_take) begin
			best_q      <= rd_rec_s1;
			best_play_q <= cand_play;
			best_idx_q  <= rd_idx_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rec_q  <= best_q;
			out_stut_q <= !best_play_q;
			out_drop_q <= ovf_q;
			out_last_q <= last_pick;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_tag       = out_rec_q.tag;
	assign out_rank      = out_rec_q.rank;
	assign out_bitrate   = out_rec_q.bitrate;
	assign is_stuttering = out_stut_q;
	assign dropped_any   = out_drop_q;
	assign last_item     = out_last_q;

	// checks
	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(MAX_LINKS), "link count beyond store depth")
	`ASSERT_ALWAYS(a_done_bound, (state_q == ST_IDLE) || (done_q < count_q), "emit count overran store")
	`ASSERT_ALWAYS(a_emit_has_best, (state_q != ST_EMIT) || best_vld_q, "emit with no candidate picked")
	`ASSERT_NEXT(a_last_clears, out_load && last_pick, (state_q == ST_IDLE) && (count_q == '0) && !ovf_q, "store not cleared after last beat")

endmodule

/* bench/slrs_checker.sv */
// checker for the link sorter: tracks stored links, predicts each sorted list and compares beats
`timescale 1ns / 1ps

module slrs_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           command,
	input  logic [slrs_pkg::TAG_W-1:0]     link_tag,
	input  logic [slrs_pkg::RANK_W-1:0]    link_rank,
	input  logic [slrs_pkg::RATE_W-1:0]    link_bitrate,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [slrs_pkg::TAG_W-1:0]     out_tag,
	input  logic [slrs_pkg::RANK_W-1:0]    out_rank,
	input  logic [slrs_pkg::RATE_W-1:0]    out_bitrate,
	input  logic                           is_stuttering,
	input  logic                           dropped_any,
	input  logic                           last_item,
	input  logic                           cfg_we,
	input  logic [slrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [slrs_pkg::CFG_DAT_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             pending,
	output int                             checked
);
	import slrs_pkg::*;

	// one predicted output beat
	typedef struct packed {
		link_rec_t rec;
		logic      stutter;
		logic      dropped;
		logic      last;
	} sorted_link_t;

	// mirror of the block state and window
	link_rec_t         held [MAX_LINKS];
	int                held_n;
	logic              held_drop;
	logic [RATE_W-1:0] win_lo;
	logic [RATE_W-1:0] win_hi;

	sorted_link_t sorted_q [$];
	int           errors = 0;
	int           seen = 0;

	initial begin
		fail_count = 0;
		pending = 0;
		checked = 0;
	end

	function automatic logic in_window(logic [RATE_W-1:0] rate);
		return (rate >= win_lo) && (rate <= win_hi);
	endfunction

	// playable ahead of stuttering; within a group the group's own key order
	function automatic logic goes_first(link_rec_t a, link_rec_t b);
		logic a_ok;
		logic b_ok;
		a_ok = in_window(a.bitrate);
		b_ok = in_window(b.bitrate);
		if (a_ok != b_ok)
			return a_ok;
		if (a_ok)
			return (a.rank != b.rank) ? (a.rank > b.rank) : (a.bitrate > b.bitrate);
		return (a.bitrate != b.bitrate) ? (a.bitrate < b.bitrate) : (a.rank > b.rank);
	endfunction

	// stable insertion sort of the held links, queued as expected beats
	task automatic predict_list();
		link_rec_t    order [MAX_LINKS];
		link_rec_t    key;
		sorted_link_t beat;
		int           j;
		for (int i = 0; i < held_n; i++)
			order[i] = held[i];
		for (int i = 1; i < held_n; i++) begin
			key = order[i];
			j = i;
			while (j > 0 && goes_first(key, order[j-1])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = key;
		end
		for (int k = 0; k < held_n; k++) begin
			beat.rec     = order[k];
			beat.stutter = !in_window(order[k].bitrate);
			beat.dropped = held_drop;
			beat.last    = (k == held_n - 1);
			sorted_q.insert(sorted_q.size(), beat);
		end
		held_n = 0;
		held_drop = 1'b0;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endtask

	// compare one output beat with the oldest prediction
	task automatic check_beat();
		sorted_link_t want;
		if (sorted_q.size() == 0) begin
			$error("output beat with nothing expected: tag %0h", out_tag);
			errors++;
		end else begin
			want = sorted_q.pop_front();
			check_field("out_tag", want.rec.tag, out_tag);
			check_field("out_rank", want.rec.rank, out_rank);
			check_field("out_bitrate", want.rec.bitrate, out_bitrate);
			check_field("is_stuttering", want.stutter, is_stuttering);
			check_field("dropped_any", want.dropped, dropped_any);
			check_field("last_item", want.last, last_item);
			seen++;
		end
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_n = 0;
			held_drop = 1'b0;
			win_lo = '0;
			win_hi = MAX_RATE_RESET;
			sorted_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_beat();
			if (in_valid && !in_stall) begin
				if (command == CMD_ADD) begin
					if (held_n < MAX_LINKS) begin
						held[held_n] = '{tag: link_tag, rank: link_rank, bitrate: link_bitrate};
						held_n++;
					end else begin
						held_drop = 1'b1;
					end
				end else begin
					predict_list();
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_BITRATE: win_lo = cfg_data;
					REG_MAX_BITRATE: win_hi = cfg_data;
					default: ;
				endcase
			end
			pending    <= sorted_q.size();
			fail_count <= errors;
			checked    <= seen;
		end
	end

endmodule

/* bench/tb_stream_link_ranking_sorter_top.sv */
// testbench top for the link sorter: clock, reset, stimulus, stall pattern and verdict
`timescale 1ns / 1ps

module tb_stream_link_ranking_sorter_top;
	import slrs_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_CYCLES  = 400;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PHASE_BEATS   = 125;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 command = CMD_ADD;
	logic [TAG_W-1:0]     link_tag = '0;
	logic [RANK_W-1:0]    link_rank = '0;
	logic [RATE_W-1:0]    link_bitrate = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [TAG_W-1:0]     out_tag;
	logic [RANK_W-1:0]    out_rank;
	logic [RATE_W-1:0]    out_bitrate;
	logic                 is_stuttering;
	logic                 dropped_any;
	logic                 last_item;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_BITRATE;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int checked;

	// stimulus bookkeeping
	int                idle_pct = 0;
	int                stall_pct = 0;
	int                beats_sent = 0;
	int                lists_sent = 0;
	int                windows_set = 0;
	int                quiet_cycles = 0;
	logic [RATE_W-1:0] win_lo = '0;
	logic [RATE_W-1:0] win_hi = MAX_RATE_RESET;

	stream_link_ranking_sorter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.link_tag(link_tag), .link_rank(link_rank), .link_bitrate(link_bitrate),
		.out_valid(out_valid), .out_stall(out_stall), .out_tag(out_tag),
		.out_rank(out_rank), .out_bitrate(out_bitrate), .is_stuttering(is_stuttering),
		.dropped_any(dropped_any), .last_item(last_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	slrs_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.link_tag(link_tag), .link_rank(link_rank), .link_bitrate(link_bitrate),
		.out_valid(out_valid), .out_stall(out_stall), .out_tag(out_tag),
		.out_rank(out_rank), .out_bitrate(out_bitrate), .is_stuttering(is_stuttering),
		.dropped_any(dropped_any), .last_item(last_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver stall pattern
	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results pending",
				quiet_cycles, pending);
			$display("Verification failed");
			$finish;
		end
	end

	// one input beat, with random sender gaps ahead of it
	task automatic send_beat(logic cmd, logic [TAG_W-1:0] tag, logic [RANK_W-1:0] rank,
			logic [RATE_W-1:0] rate);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		link_tag     <= tag;
		link_rank    <= rank;
		link_bitrate <= rate;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		if (cmd == CMD_FINALIZE)
			lists_sent++;
	endtask

	// wait until every expected beat is out and the block has settled
	task automatic wait_idle(int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_window(logic [RATE_W-1:0] lo, logic [RATE_W-1:0] hi);
		wait_idle(SETTLE_CYCLES);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MIN_BITRATE;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_MAX_BITRATE;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_lo = lo;
		win_hi = hi;
		windows_set++;
	endtask

	// bit rates biased onto and just past the window edges
	function automatic logic [RATE_W-1:0] pick_rate();
		case ($urandom_range(7))
			0: return win_lo;
			1: return win_hi;
			2: return win_lo - 1'b1;
			3: return win_hi + 1'b1;
			4: return '0;
			5: return '1;
			default: return RATE_W'($urandom);
		endcase
	endfunction

	// ranks biased towards ties and extremes
	function automatic logic [RANK_W-1:0] pick_rank();
		case ($urandom_range(3))
			0: return RANK_W'($urandom_range(3));
			1: return $urandom_range(1) ? '1 : '0;
			default: return RANK_W'($urandom);
		endcase
	endfunction

	task automatic random_window();
		logic [RATE_W-1:0] a;
		logic [RATE_W-1:0] b;
		a = RATE_W'($urandom);
		b = RATE_W'($urandom);
		case ($urandom_range(6))
			0: set_window('0, '1);
			1: set_window('0, '0);
			2: set_window('1, '1);
			3: set_window('1, '0);
			4: set_window((a < b) ? a : b, (a < b) ? b : a);
			5: set_window((a > b) ? a : b, (a > b) ? b : a);
			default: set_window(a, a);
		endcase
	endtask

	// random lists: mostly adds then finalize, some overflow, some noise
	task automatic run_random(int beats);
		int stop_at;
		int n;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			if ($urandom_range(99) < 30)
				random_window();
			if ($urandom_range(9) == 0) begin
				// noise: random commands mixed in
				n = $urandom_range(1, 12);
				repeat (n)
					send_beat(($urandom_range(5) == 0) ? CMD_FINALIZE : CMD_ADD,
						TAG_W'($urandom), pick_rank(), pick_rate());
			end else begin
				case ($urandom_range(9))
					0: n = 0;
					1: n = $urandom_range(MAX_LINKS + 1, MAX_LINKS + 4);
					2, 3, 4: n = $urandom_range(9, MAX_LINKS);
					default: n = $urandom_range(1, 8);
				endcase
				repeat (n)
					send_beat(CMD_ADD, TAG_W'($urandom), pick_rank(), pick_rate());
				send_beat(CMD_FINALIZE, TAG_W'($urandom), RANK_W'($urandom),
					RATE_W'($urandom));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 15;
		stall_pct = 47;

		// empty finalize under the reset window
		set_window('0, '1);
		send_beat(CMD_FINALIZE, '1, '1, '1);

		// extremes, window edges, ties and an add to a full store
		set_window(20'h00100, 20'h80000);
		send_beat(CMD_ADD, 16'h0000, 16'h0000, 20'h00000);
		send_beat(CMD_ADD, 16'hffff, 16'hffff, 20'hfffff);
		send_beat(CMD_ADD, 16'h0001, 16'h0100, 20'h00100);
		send_beat(CMD_ADD, 16'h0002, 16'h0100, 20'h00100);
		send_beat(CMD_ADD, 16'h0003, 16'h0100, 20'h80000);
		send_beat(CMD_ADD, 16'h0004, 16'hffff, 20'h0ff00);
		send_beat(CMD_ADD, 16'h0005, 16'h0000, 20'h80001);
		send_beat(CMD_ADD, 16'h0006, 16'h0005, 20'h000ff);
		send_beat(CMD_ADD, 16'h0007, 16'h0006, 20'h000ff);
		send_beat(CMD_ADD, 16'h0008, 16'h0006, 20'h000ff);
		send_beat(CMD_ADD, 16'haaaa, 16'h5555, 20'h55555);
		send_beat(CMD_ADD, 16'h5555, 16'haaaa, 20'haaaaa);
		send_beat(CMD_ADD, 16'h0009, 16'h0000, 20'h00100);
		send_beat(CMD_ADD, 16'h000a, 16'hffff, 20'hfffff);
		send_beat(CMD_ADD, 16'h000b, 16'h8000, 20'h80000);
		send_beat(CMD_ADD, 16'h000c, 16'h7fff, 20'h7ffff);
		send_beat(CMD_ADD, 16'h000d, 16'h1234, 20'h12345);
		send_beat(CMD_FINALIZE, '0, '0, '0);

		// single link after an overflow list: drop flag must be clear
		send_beat(CMD_ADD, 16'hfffe, 16'h0001, 20'h00200);
		send_beat(CMD_FINALIZE, '0, '0, '0);

		// inverted window makes every link stutter
		set_window('1, '0);
		send_beat(CMD_ADD, 16'h0010, 16'h0003, 20'h00000);
		send_beat(CMD_ADD, 16'h0011, 16'h0003, 20'hfffff);
		send_beat(CMD_ADD, 16'h0012, 16'h0009, 20'h00000);
		send_beat(CMD_FINALIZE, '0, '0, '0);

		run_random(PHASE_BEATS);

		idle_pct  = 47;
		stall_pct = 15;
		run_random(PHASE_BEATS);

		idle_pct  = 0;
		stall_pct = 0;
		run_random(PHASE_BEATS);

		wait_idle(DRAIN_CYCLES);
		$display("run covered %0d input beats in %0d finalize commands, %0d windows",
			beats_sent, lists_sent, windows_set);
		$display("%0d sorted link beats compared, %0d mismatches", checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/slrs_pkg.sv
design/stream_link_ranking_sorter_top.sv
bench/slrs_checker.sv
bench/tb_stream_link_ranking_sorter_top.sv
